// ===== sv/cht_pkg.sv =====
package cht_pkg;

	// default sizes and reset values
	localparam int MAX_BUCKETS_DEF  = 128;
	localparam int BUCKET_DEPTH_DEF = 8;
	localparam int KEY_W            = 32;
	localparam int VAL_W            = 32;
	localparam int CNT_W            = 11;
	localparam int BC_W             = 8;

	localparam logic [BC_W-1:0]  RESET_BUCKETS = 8'd101;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 11'd2047;

	// action codes
	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_ABSENT = 2'd1;
	localparam logic [1:0] STAT_DUP    = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] value_out;
		logic [CNT_W-1:0] entry_count;
		logic             table_empty;
	} res_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_FILL,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

endpackage

// ===== sv/cht_mod.sv =====
module cht_mod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cht_pkg::KEY_W-1:0] dividend,
	input  logic [cht_pkg::BC_W-1:0]  divisor,
	output logic                     done,
	output logic [cht_pkg::BC_W-1:0]  rem
);
	import cht_pkg::*;

	localparam int STEP_W = $clog2(KEY_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [KEY_W-1:0]  dvd_q;
	logic [BC_W-1:0]   rem_q;
	logic [BC_W-1:0]   div_q;
	logic [BC_W:0]     trial;
	logic [BC_W-1:0]   rem_nxt;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[KEY_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_nxt = BC_W'(trial - {1'b0, div_q});
		end else begin
			rem_nxt = trial[BC_W-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q  <= cnt_q + STEP_W'(1);
				busy_q <= (cnt_q != STEP_W'(KEY_W - 1));
				done_q <= (cnt_q == STEP_W'(KEY_W - 1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// operand and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== sv/chained_hash_table_top.sv =====
// channel   direction  handshake                    payload
// request   in         start, taken when !busy      req  (action, key, value)
// result    out        done, one-cycle strobe       res  (status, value_out, entry_count,
//                                                         table_empty)
// config    in         cfg_valid / cfg_ready        cfg_data (bucket count)
//
// one request at a time: busy stays high from the accept edge through the modulo (one
// restoring step per dividend bit and its done strobe), a bucket fill read, a read and a
// compare per entry, a further check if no entry matches, a decide step, on a remove a read
// and a write per entry moved plus a fill update, and a result step; then busy drops.
// the modulo is a bit-serial remainder unit; the scan and the gap close go
// through the single read and single write port of the slot memories.
// after reset the bucket fill memory is cleared one bucket a cycle
// with busy high; config writes are taken meanwhile.
// the result receiver cannot stall: done is high for exactly one cycle.
module chained_hash_table_top #(
	parameter int MAX_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF,
	parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  cht_pkg::req_t           req,
	output logic                    done,
	output cht_pkg::res_t           res,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [cht_pkg::BC_W-1:0] cfg_data
);
	import cht_pkg::*;

	localparam int SLOTS = MAX_BUCKETS * BUCKET_DEPTH;
	localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW    = $clog2(BUCKET_DEPTH + 1);
	localparam int TW    = $clog2(SLOTS + 1);

	state_t state_q, nxt;

	logic [BC_W-1:0]  bc_q;
	logic [BC_W-1:0]  live_bc;
	logic [TW-1:0]    total_q;
	logic [BW-1:0]    clr_idx_q;

	logic [1:0]       action_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic [BW-1:0]    bucket_q;
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    idx_q;
	logic             found_q;
	logic [1:0]       status_q;
	logic [VAL_W-1:0] vout_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;

	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [VAL_W-1:0] val_mem [SLOTS];
	logic [FW-1:0]    fill_mem [MAX_BUCKETS];

	logic             div_start;
	logic             div_done;
	logic [BC_W-1:0]  div_rem;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [KEY_W-1:0] mem_wkey;
	logic [VAL_W-1:0] mem_wval;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic             fill_we;
	logic [BW-1:0]    fill_waddr;
	logic [FW-1:0]    fill_wdata;
	logic             total_inc;
	logic             total_dec;
	logic [FW:0]      idx_inc;

	function automatic logic [AW-1:0] slot_of(input logic [BW-1:0] b, input logic [FW-1:0] i);
		slot_of = AW'(b) * AW'(BUCKET_DEPTH) + AW'(i);
	endfunction

	// bucket count register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= RESET_BUCKETS;
		end else if (cfg_valid && cfg_ready) begin
			bc_q <= cfg_data;
		end
	end

	// clamp the divisor to 1..MAX_BUCKETS
	always_comb begin
		if (bc_q == '0) begin
			live_bc = BC_W'(1);
		end else if (32'(bc_q) > MAX_BUCKETS) begin
			live_bc = BC_W'(MAX_BUCKETS);
		end else begin
			live_bc = bc_q;
		end
	end

	// key mod bucket count
	cht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.key),
		.divisor  (live_bc),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign idx_inc = {1'b0, idx_q} + (FW+1)'(1);

	// next state and memory controls
	always_comb begin
		nxt        = state_q;
		div_start  = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = slot_of(bucket_q, idx_q);
		mem_wkey   = rd_key_q;
		mem_wval   = rd_val_q;
		mem_re     = 1'b0;
		mem_raddr  = slot_of(bucket_q, idx_q);
		fill_we    = 1'b0;
		fill_waddr = bucket_q;
		fill_wdata = fill_q;
		total_inc  = 1'b0;
		total_dec  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_idx_q;
				fill_wdata = '0;
				if (clr_idx_q == BW'(MAX_BUCKETS - 1)) begin
					nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					div_start = 1'b1;
					nxt       = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					nxt = S_FILL;
				end
			end
			S_FILL: begin
				nxt = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (idx_q == fill_q) begin
					nxt = S_DECIDE;
				end else begin
					mem_re = 1'b1;
					nxt    = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (rd_key_q == key_q) begin
					nxt = S_DECIDE;
				end else begin
					nxt = S_SCAN_RD;
				end
			end
			S_DECIDE: begin
				nxt = S_DONE;
				if (action_q == ACT_ADD && !found_q && fill_q != FW'(BUCKET_DEPTH)) begin
					mem_we     = 1'b1;
					mem_waddr  = slot_of(bucket_q, fill_q);
					mem_wkey   = key_q;
					mem_wval   = value_q;
					fill_we    = 1'b1;
					fill_wdata = fill_q + FW'(1);
					total_inc  = 1'b1;
				end else if (action_q == ACT_REMOVE && found_q) begin
					nxt = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (idx_inc >= {1'b0, fill_q}) begin
					fill_we    = 1'b1;
					fill_wdata = fill_q - FW'(1);
					total_dec  = 1'b1;
					nxt        = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = slot_of(bucket_q, idx_inc[FW-1:0]);
					nxt       = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
				nxt    = S_SHIFT_RD;
			end
			S_DONE: begin
				nxt = S_IDLE;
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			total_q   <= '0;
			clr_idx_q <= '0;
		end else begin
			state_q <= nxt;
			if (state_q == S_CLEAR) begin
				clr_idx_q <= clr_idx_q + BW'(1);
			end
			if (total_inc) begin
				total_q <= total_q + TW'(1);
			end else if (total_dec) begin
				total_q <= total_q - TW'(1);
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					action_q <= req.action;
					key_q    <= req.key;
					value_q  <= req.value;
				end
			end
			S_DIV: begin
				if (div_done) begin
					bucket_q <= BW'(div_rem);
				end
			end
			S_FILL: begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			S_SCAN_CMP: begin
				if (rd_key_q == key_q) begin
					found_q <= 1'b1;
				end else begin
					idx_q <= idx_q + FW'(1);
				end
			end
			S_DECIDE: begin
				unique case (action_q)
					ACT_ADD: begin
						vout_q <= '0;
						if (found_q) begin
							status_q <= STAT_DUP;
						end else if (fill_q == FW'(BUCKET_DEPTH)) begin
							status_q <= STAT_FULL;
						end else begin
							status_q <= STAT_OK;
						end
					end
					ACT_REMOVE: begin
						vout_q   <= '0;
						status_q <= found_q ? STAT_OK : STAT_ABSENT;
					end
					default: begin
						status_q <= found_q ? STAT_OK : STAT_ABSENT;
						vout_q   <= found_q ? rd_val_q : '0;
					end
				endcase
			end
			S_SHIFT_WR: begin
				idx_q <= idx_q + FW'(1);
			end
			default: begin
			end
		endcase
	end

	// slot memories: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wkey;
			val_mem[mem_waddr] <= mem_wval;
		end
		if (mem_re) begin
			rd_key_q <= key_mem[mem_raddr];
			rd_val_q <= val_mem[mem_raddr];
		end
	end

	// bucket fill memory
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (state_q == S_FILL) begin
			fill_q <= fill_mem[bucket_q];
		end
	end

	// result
	assign busy              = (state_q != S_IDLE);
	assign done              = (state_q == S_DONE);
	assign res.status        = status_q;
	assign res.value_out     = vout_q;
	assign res.entry_count   = (32'(total_q) > 32'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(total_q);
	assign res.table_empty   = (total_q == '0);

endmodule

// ===== sv/cht_chk.sv =====
module cht_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input cht_pkg::res_t res
);
	import cht_pkg::*;

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// a result is only presented while the block is busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// one result per request, the result strobe is a single pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// empty flag agrees with the entry count
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.table_empty == (res.entry_count == '0)))
		else $error("empty flag disagrees with entry count");

	// a value comes back only with a successful status
	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status != STAT_OK |-> res.value_out == '0)
		else $error("value returned on a failed request");

endmodule

bind chained_hash_table_top cht_chk u_cht_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);
